// ===== hw/rtl/decimal_price_parser_macros.svh =====
// Assertion macros shared by the price parser RTL.
// Each macro checks a property on the rising edge of clk_i, disabled while rst_ni is low.
`ifndef DECIMAL_PRICE_PARSER_MACROS_SVH
`define DECIMAL_PRICE_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Plain condition that must hold on every cycle out of reset.
`define DPP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define DPP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define DPP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define DPP_ASSERT(lbl, cond)
`define DPP_ASSERT_IMP(lbl, ante, cons)
`define DPP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/dpp_pkg.sv =====
`default_nettype none

package dpp_pkg;

  // Field and register widths.
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned PlacesWidth  = 5;
  localparam int unsigned AmountWidth  = 63;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;

  // Defaults.
  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [PlacesWidth-1:0] PlacesReset = 5'd4;

  // Register index, taken from the word address bits of paddr.
  localparam logic [ApbAddrWidth-3:0] RegIdxDecimalPlaces = '0;

  // Saturation bound, and the largest value that can be scaled by ten without overflow.
  localparam logic [AmountWidth-1:0] AmountMax     = '1;
  localparam logic [AmountWidth-1:0] TimesTenLimit = AmountMax / 10;

  // Character codes.
  localparam logic [CharWidth-1:0] CharNul        = 8'h00;
  localparam logic [CharWidth-1:0] CharComma      = 8'h2C;
  localparam logic [CharWidth-1:0] CharBraceClose = 8'h7D;
  localparam logic [CharWidth-1:0] CharSpace      = 8'h20;
  localparam logic [CharWidth-1:0] CharPoint      = 8'h2E;
  localparam logic [CharWidth-1:0] CharZero       = 8'h30;
  localparam logic [CharWidth-1:0] CharNine       = 8'h39;

  // Largest digit for which the overflow bound is still TimesTenLimit.
  localparam logic [3:0] DigitBoundary = 4'd7;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk        = 2'd0,
    StatusInvalid   = 2'd1,
    StatusSaturated = 2'd2
  } status_e;

  // One finished number on its way to the scaling stage.
  typedef struct packed {
    logic [AmountWidth-1:0] value;
    logic [PlacesWidth-1:0] steps;
    logic                   saturated;
    logic                   invalid;
  } dpp_job_t;

  // Multiply by ten as two shifted copies; the caller guards against overflow.
  function automatic logic [AmountWidth-1:0] times_ten(input logic [AmountWidth-1:0] v);
    return {v[AmountWidth-4:0], 3'b000} + {v[AmountWidth-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dpp_front.sv =====
`default_nettype none

module dpp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [dpp_pkg::CharWidth-1:0]  char_code_i,
  input  logic                           is_last_i,
  input  logic [dpp_pkg::PlacesWidth-1:0] decimal_places_i,
  input  logic                           job_full_i,
  output logic                           job_push_o,
  output dpp_pkg::dpp_job_t              job_o
);
  import dpp_pkg::*;

  logic [AmountWidth-1:0] acc_q, acc_d;
  logic                   point_q, point_d;
  logic [PlacesWidth-1:0] frac_q, frac_d;
  logic                   fin_q, fin_d;
  logic                   ovf_q, ovf_d;

  logic                   accept;
  logic                   is_term;
  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [AmountWidth-1:0] acc_limit;
  logic                   acc_ovf;
  logic [AmountWidth-1:0] acc_ten;
  logic                   res_ok;
  logic                   res_inv;

  // A character is taken only while the job queue has room.
  assign accept = push_i & ~job_full_i;
  assign full_o = job_full_i;

  // Character classes.
  assign is_term  = (char_code_i == CharNul) || (char_code_i == CharComma) ||
                    (char_code_i == CharBraceClose) || (char_code_i == CharSpace);
  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit_val = char_code_i[3:0];

  // Saturating multiply-accumulate: overflow when acc * 10 + digit exceeds the maximum.
  assign acc_limit = (digit_val > DigitBoundary) ? TimesTenLimit - 1'b1 : TimesTenLimit;
  assign acc_ovf   = acc_q > acc_limit;
  assign acc_ten   = times_ten(acc_q) + AmountWidth'(digit_val);

  // Next number state and the finished-number request.
  always_comb begin
    acc_d   = acc_q;
    point_d = point_q;
    frac_d  = frac_q;
    fin_d   = fin_q;
    ovf_d   = ovf_q;
    res_ok  = 1'b0;
    res_inv = 1'b0;
    if (!fin_q) begin
      if (is_term) begin
        res_ok = 1'b1;
      end else if (is_digit) begin
        if (point_q && (frac_q == decimal_places_i)) begin
          // A fraction digit beyond the precision ends the number and is dropped.
          res_ok = 1'b1;
        end else begin
          if (point_q) begin
            frac_d = frac_q + 1'b1;
          end
          if (acc_ovf) begin
            acc_d = AmountMax;
            ovf_d = 1'b1;
          end else begin
            acc_d = acc_ten;
          end
        end
      end else if ((char_code_i == CharPoint) && !point_q) begin
        point_d = 1'b1;
      end else begin
        res_inv = 1'b1;
      end
      // The last character closes an open number like a terminator.
      if (is_last_i && !res_ok && !res_inv) begin
        res_ok = 1'b1;
      end
    end

    job_o.value     = res_inv ? '0 : acc_d;
    job_o.steps     = (decimal_places_i > frac_d) ? decimal_places_i - frac_d : '0;
    job_o.saturated = ovf_d;
    job_o.invalid   = res_inv;

    if (res_ok || res_inv) begin
      fin_d = 1'b1;
    end
    // The last character starts a fresh number.
    if (is_last_i) begin
      acc_d   = '0;
      point_d = 1'b0;
      frac_d  = '0;
      fin_d   = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  assign job_push_o = accept & (res_ok | res_inv);

  // Number state, updated on each accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      point_q <= 1'b0;
      frac_q  <= '0;
      fin_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      acc_q   <= acc_d;
      point_q <= point_d;
      frac_q  <= frac_d;
      fin_q   <= fin_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dpp_fifo.sv =====
`default_nettype none
`include "decimal_price_parser_macros.svh"

module dpp_fifo #(
  parameter int unsigned Depth = dpp_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpp_pkg::dpp_job_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output dpp_pkg::dpp_job_t data_o,
  output logic              empty_o
);
  import dpp_pkg::*;

  localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  dpp_job_t                mem_q [Depth];
  logic [PtrWidth-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountWidth-1:0]   count_q, count_d;

  assign full_o  = (count_q == CountWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `DPP_ASSERT(fifo_no_overflow_a, !(push_i && full_o))
  `DPP_ASSERT(fifo_no_underflow_a, !(pop_i && empty_o))
  `DPP_ASSERT(fifo_count_bound_a, count_q <= CountWidth'(Depth))

endmodule

`default_nettype wire

// ===== hw/rtl/dpp_back.sv =====
`default_nettype none
`include "decimal_price_parser_macros.svh"

module dpp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  dpp_pkg::dpp_job_t                job_i,
  output logic                             job_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output logic [dpp_pkg::AmountWidth-1:0]  amount_o,
  output logic [dpp_pkg::StatusWidth-1:0]  status_o
);
  import dpp_pkg::*;

  logic                   work_valid_q, work_valid_d;
  logic [AmountWidth-1:0] work_value_q, work_value_d;
  logic [PlacesWidth-1:0] work_steps_q, work_steps_d;
  logic                   work_sat_q, work_sat_d;
  logic                   work_inv_q, work_inv_d;

  logic                   out_valid_q, out_valid_d;
  logic [AmountWidth-1:0] amount_q, amount_d;
  status_e                status_q, status_d;

  logic                   work_done;
  logic                   out_free;
  logic                   move;
  logic                   load;

  // Handoff between the scaling register and the result register.
  assign work_done = work_valid_q && (work_steps_q == '0);
  assign out_free  = !out_valid_q || pop_i;
  assign move      = work_done && out_free;
  assign load      = job_valid_i && (!work_valid_q || move);
  assign job_pop_o = load;

  // Scaling: one saturating multiply by ten per cycle for each missing place.
  always_comb begin
    work_valid_d = work_valid_q;
    work_value_d = work_value_q;
    work_steps_d = work_steps_q;
    work_sat_d   = work_sat_q;
    work_inv_d   = work_inv_q;
    if (load) begin
      work_valid_d = 1'b1;
      work_value_d = job_i.value;
      work_steps_d = job_i.steps;
      work_sat_d   = job_i.saturated;
      work_inv_d   = job_i.invalid;
    end else if (move) begin
      work_valid_d = 1'b0;
    end else if (work_valid_q && (work_steps_q != '0)) begin
      work_steps_d = work_steps_q - 1'b1;
      if (work_value_q > TimesTenLimit) begin
        work_value_d = AmountMax;
        work_sat_d   = 1'b1;
      end else begin
        work_value_d = times_ten(work_value_q);
      end
    end
  end

  // Result register in front of the output queue interface.
  always_comb begin
    out_valid_d = out_valid_q;
    amount_d    = amount_q;
    status_d    = status_q;
    if (move) begin
      out_valid_d = 1'b1;
      amount_d    = work_value_q;
      if (work_inv_q) begin
        status_d = StatusInvalid;
      end else if (work_sat_q) begin
        status_d = StatusSaturated;
      end else begin
        status_d = StatusOk;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_value_q <= work_value_d;
    work_steps_q <= work_steps_d;
    work_sat_q   <= work_sat_d;
    work_inv_q   <= work_inv_d;
    amount_q     <= amount_d;
    status_q     <= status_d;
  end

  assign empty_o  = !out_valid_q;
  assign amount_o = amount_q;
  assign status_o = status_q;

  `DPP_ASSERT_IMP(back_invalid_zero_a, out_valid_q && (status_q == StatusInvalid), amount_q == '0)
  `DPP_ASSERT_NXT(back_busy_holds_a, work_valid_q && (work_steps_q != '0), work_valid_q)
  `DPP_ASSERT_NXT(back_step_count_a, work_valid_q && (work_steps_q != '0),
                  work_steps_q == $past(work_steps_q) - 1'b1)

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_price_parser.sv =====
// Decimal price parser: one ASCII character accepted per cycle while the job queue has room;
// numbers come out as scaled integers. The scaling unit multiplies a result by ten once per
// missing fraction place (decimal_places minus fraction digits seen), one result at a time.
// A finished number goes through the job queue, then the scaling and the result registers.
// A job queue between parser and scaler absorbs scaling time; full rises when it fills.
// Reset (rst_ni low, asynchronous) clears the number state and the queues; decimal_places is 4.
`default_nettype none

module decimal_price_parser #(
  parameter int unsigned QueueDepth = dpp_pkg::QueueDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Character input
  input  logic                              push,
  output logic                              full,
  input  logic [dpp_pkg::CharWidth-1:0]     char_code_i,
  input  logic                              is_last_i,
  // Result output
  output logic                              empty,
  input  logic                              pop,
  output logic [dpp_pkg::AmountWidth-1:0]   amount_o,
  output logic [dpp_pkg::StatusWidth-1:0]   status_o,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dpp_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [dpp_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [dpp_pkg::ApbDataWidth-1:0]  prdata,
  output logic                              pready
);
  import dpp_pkg::*;

  logic [PlacesWidth-1:0] places_q;
  logic                   cfg_write;
  logic                   reg_sel;

  dpp_job_t               front_job;
  logic                   front_push;
  dpp_job_t               back_job;
  logic                   back_pop;
  logic                   q_full;
  logic                   q_empty;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[ApbAddrWidth-1:2] == RegIdxDecimalPlaces);
  assign cfg_write = psel && penable && pwrite && reg_sel;
  assign prdata    = reg_sel ? ApbDataWidth'(places_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      places_q <= PlacesReset;
    end else if (cfg_write) begin
      places_q <= pwdata[PlacesWidth-1:0];
    end
  end

  // Parser front end.
  dpp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .char_code_i      (char_code_i),
    .is_last_i        (is_last_i),
    .decimal_places_i (places_q),
    .job_full_i       (q_full),
    .job_push_o       (front_push),
    .job_o            (front_job)
  );

  // Queue of finished numbers.
  dpp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (back_pop),
    .data_o  (back_job),
    .empty_o (q_empty)
  );

  // Scaling and result register.
  dpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (back_job),
    .job_pop_o   (back_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .amount_o    (amount_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== tb/price_parse_checker.sv =====
`timescale 1ns / 1ps

// Watches the character and result channels of the price parser, predicts every
// parsed number from the accepted characters and compares it with what the block gives.
module price_parse_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic [dpp_pkg::CharWidth-1:0]    char_code_i,
  input  logic                             is_last_i,
  input  logic                             empty_i,
  input  logic                             pop_i,
  input  logic [dpp_pkg::AmountWidth-1:0]  amount_i,
  input  logic [dpp_pkg::StatusWidth-1:0]  status_i,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic                             pready_i,
  input  logic [dpp_pkg::ApbAddrWidth-1:0] paddr_i,
  input  logic [dpp_pkg::ApbDataWidth-1:0] pwdata_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               handled_o,
  output int                               results_o
);
  import dpp_pkg::*;

  typedef struct {
    logic [AmountWidth-1:0] amount;
    status_e                status;
  } parsed_t;

  // Predicted numbers still waiting for the block to deliver them.
  parsed_t parsed_q[$];

  // Our own copy of the number state and of the decimal places register.
  logic [AmountWidth-1:0] acc_q;
  logic                   point_q;
  logic [PlacesWidth-1:0] frac_q;
  logic                   done_q;
  logic                   ovf_q;
  logic [PlacesWidth-1:0] places_q;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // Append one predicted number at the tail of the waiting list.
  function automatic void queue_result(input parsed_t item);
    parsed_q.insert(parsed_q.size(), item);
  endfunction

  // Saturating a * 10 + digit; saturation marks the number as overflowed.
  function automatic logic [AmountWidth-1:0] scale_add(input logic [AmountWidth-1:0] a,
                                                       input logic [3:0] digit);
    logic [63:0] bound;
    bound = (64'(AmountMax) - 64'(digit)) / 64'd10;
    if (64'(a) > bound) begin
      ovf_q = 1'b1;
      return AmountMax;
    end
    return AmountWidth'(64'(a) * 64'd10 + 64'(digit));
  endfunction

  function automatic void clear_number();
    acc_q   = '0;
    point_q = 1'b0;
    frac_q  = '0;
    done_q  = 1'b0;
    ovf_q   = 1'b0;
  endfunction

  // Scale up for the missing fraction places and queue the finished number.
  function automatic void close_number();
    parsed_t item;
    int      k;
    item.amount = acc_q;
    for (k = int'(frac_q); k < int'(places_q); k++) begin
      item.amount = scale_add(item.amount, 4'd0);
    end
    if (ovf_q) begin
      item.status = StatusSaturated;
    end else begin
      item.status = StatusOk;
    end
    queue_result(item);
    done_q = 1'b1;
  endfunction

  // One accepted character through the number state.
  function automatic void parse_char(input logic [CharWidth-1:0] c, input logic last);
    logic    produced;
    parsed_t bad;
    produced = 1'b0;
    if (!done_q) begin
      handled_o++;
      if (c == CharNul || c == CharComma || c == CharBraceClose || c == CharSpace) begin
        close_number();
        produced = 1'b1;
      end else if (c >= CharZero && c <= CharNine) begin
        if (point_q && frac_q == places_q) begin
          // A fraction digit beyond the precision ends the number and is dropped.
          close_number();
          produced = 1'b1;
        end else begin
          if (point_q) begin
            frac_q = frac_q + 1'b1;
          end
          acc_q = scale_add(acc_q, 4'(c - CharZero));
        end
      end else if (c == CharPoint && !point_q) begin
        point_q = 1'b1;
      end else begin
        // Unknown character or a second point.
        bad.amount = '0;
        bad.status = StatusInvalid;
        queue_result(bad);
        done_q   = 1'b1;
        produced = 1'b1;
      end
      if (last && !produced) begin
        close_number();
      end
    end
    if (last) begin
      clear_number();
    end
  endfunction

  task automatic check_result();
    parsed_t want;
    if (parsed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result amount %0d status %0d",
                                amount_i, status_i));
      return;
    end
    want = parsed_q.pop_front();
    results_o++;
    if (amount_i !== want.amount) begin
      report_mismatch($sformatf("amount %0d, expected %0d", amount_i, want.amount));
    end
    if (status_i !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
    end
  endtask

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      places_q = PlacesReset;
      clear_number();
      parsed_q.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[ApbAddrWidth-1:2] == RegIdxDecimalPlaces) begin
        places_q = pwdata_i[PlacesWidth-1:0];
      end
      if (push_i && !full_i) begin
        parse_char(char_code_i, is_last_i);
      end
      if (pop_i && !empty_i) begin
        check_result();
      end
      pending_o = parsed_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dpp_pkg::*;

  // Decimal place settings visited after the directed part, extremes included.
  localparam int NumPhases = 8;
  localparam int PhasePlaces [NumPhases] = '{0, 18, 1, 31, 2, 19, 7, 4};
  localparam int PhaseChars  = 160;
  localparam int SettlePad   = 200;
  localparam int HoldCycles  = 400;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    push;
  logic                    full;
  logic [CharWidth-1:0]    char_code;
  logic                    is_last;
  logic                    empty;
  logic                    pop;
  logic [AmountWidth-1:0]  amount;
  logic [StatusWidth-1:0]  status;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  int fail_count;
  int pending;
  int handled;
  int results;

  int                     send_idle_pct = 10;
  int                     pop_idle_pct  = 10;
  bit                     hold_req      = 1'b0;
  int                     full_stalls   = 0;
  int                     sent          = 0;
  logic [PlacesWidth-1:0] places;

  decimal_price_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .char_code_i (char_code),
    .is_last_i   (is_last),
    .empty       (empty),
    .pop         (pop),
    .amount_o    (amount),
    .status_o    (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  price_parse_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .char_code_i  (char_code),
    .is_last_i    (is_last),
    .empty_i      (empty),
    .pop_i        (pop),
    .amount_i     (amount),
    .status_i     (status),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .handled_o    (handled),
    .results_o    (results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Count cycles in which a request is held off by a full input.
  always @(posedge clk) begin
    if (rst_n && push && full) begin
      full_stalls++;
    end
  end

  // Result side: random pops, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  function automatic logic [CharWidth-1:0] rand_digit();
    return CharZero + CharWidth'($urandom_range(9));
  endfunction

  function automatic logic [CharWidth-1:0] rand_terminator();
    case ($urandom_range(3))
      0: return CharNul;
      1: return CharComma;
      2: return CharBraceClose;
      default: return CharSpace;
    endcase
  endfunction

  function automatic logic [CharWidth-1:0] rand_char();
    case ($urandom_range(3))
      0: return CharWidth'($urandom_range(255));
      1: return rand_digit();
      2: return CharPoint;
      default: return rand_terminator();
    endcase
  endfunction

  // Offer one character; returns at the falling edge after it was taken, push still high.
  task automatic send_char(input logic [CharWidth-1:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    is_last   <= last;
    do @(posedge clk); while (full);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit mark_last);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_char(s[k], mark_last && (k == s.len() - 1));
    end
  endtask

  // One number with random content, or a short burst of noise; always ends with a last mark.
  task automatic send_number();
    int n_int;
    int n_frac;
    int n_noise;
    int k;
    bit nines;
    if ($urandom_range(99) < 78) begin
      n_int = ($urandom_range(9) == 0) ? $urandom_range(21, 14) : $urandom_range(6);
      nines = ($urandom_range(4) == 0);
      for (k = 0; k < n_int; k++) begin
        send_char(nines ? CharNine : rand_digit(), 1'b0);
      end
      if ($urandom_range(9) < 7) begin
        send_char(CharPoint, 1'b0);
        n_frac = $urandom_range((places + 2 > 20) ? 20 : places + 2);
        for (k = 0; k < n_frac; k++) begin
          send_char(nines ? CharNine : rand_digit(), 1'b0);
        end
        if ($urandom_range(19) == 0) begin
          send_char(CharPoint, 1'b0);
        end
      end
      if ($urandom_range(4) == 0) begin
        // The last mark itself ends the number.
        send_char(rand_digit(), 1'b1);
      end else begin
        send_char(rand_terminator(), 1'b0);
        n_noise = $urandom_range(2);
        for (k = 0; k < n_noise; k++) begin
          send_char(rand_char(), 1'b0);
        end
        send_char(rand_char(), 1'b1);
      end
    end else begin
      n_noise = $urandom_range(6, 1);
      for (k = 1; k < n_noise; k++) begin
        send_char(rand_char(), 1'b0);
      end
      send_char(rand_char(), 1'b1);
    end
  endtask

  // Stop offering, let every predicted result arrive, then let the scaler settle.
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettlePad) @(negedge clk);
  endtask

  task automatic write_places(input logic [PlacesWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegIdxDecimalPlaces, 2'b00};
    pwdata  <= ApbDataWidth'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    places = value;
  endtask

  initial begin
    int p;
    int target;
    int hold_at;
    rst_n     = 1'b0;
    push      = 1'b0;
    char_code = '0;
    is_last   = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    places    = PlacesReset;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset precision of four places.
    send_text(",", 1'b0);          // empty number
    send_char(CharNul, 1'b1);      // last mark after a finished number
    send_text("5", 1'b0);
    send_char(CharNul, 1'b1);      // NUL as terminator
    send_text("12.5 x", 1'b1);     // trailing character ignored
    send_text("3.14159}", 1'b1);   // fraction digit beyond precision
    send_text("1.2.3", 1'b1);      // second point
    send_text("7", 1'b1);          // last mark ends an open number
    send_text("8a", 1'b1);         // invalid character that is also last
    drain();

    // Random numbers under each precision setting.
    for (p = 0; p < NumPhases; p++) begin
      write_places(PlacesWidth'(PhasePlaces[p]));
      send_idle_pct = (p == 2) ? 0 : 10;
      pop_idle_pct  = (p == 2) ? 0 : 10;
      target  = sent + PhaseChars;
      hold_at = sent + 40;
      while (sent < target) begin
        if (p == 1 && hold_at > 0 && sent >= hold_at) begin
          hold_req = 1'b1;
          hold_at  = 0;
        end
        send_number();
      end
      drain();
    end

    $display("Sent %0d characters (%0d parsed live) across %0d precision phases, %0d results checked.",
             sent, handled, NumPhases + 1, results);
    $display("Input held off by a full queue for %0d cycles.", full_stalls);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dpp_pkg.sv
hw/rtl/dpp_front.sv
hw/rtl/dpp_fifo.sv
hw/rtl/dpp_back.sv
hw/rtl/decimal_price_parser.sv
tb/price_parse_checker.sv
tb/tb_top.sv
